/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the CRC-16 packet check block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/core/crc16pc_pkg.sv */
// Package for the CRC-16 packet check block: item and status types, constants,
// and the byte-wide CRC update function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crc16pc_pkg;

    localparam logic [15:0] CRC_POLY          = 16'h1021;
    localparam logic [15:0] EXPECTED_RESET    = 16'd100;
    localparam int unsigned MAX_PACKET_BYTES  = 255;
    localparam int unsigned MIN_PACKET_BYTES  = 3;
    localparam int unsigned CNT_W             = 9;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_COUNTED     = 3'd0,
        ST_NOT_COUNTED = 3'd1,
        ST_CRC_ERR     = 3'd2,
        ST_BAD_LEN     = 3'd3,
        ST_IGNORED     = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_item;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/crc16pc_if.sv */
// Handshake channel interfaces: packet bytes in, packet results out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface crc16pc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16pc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] sequence_res;
    logic [15:0] good_count;
    logic [15:0] span;
    logic        run_done;

    modport source (output valid, output status, output sequence_res, output good_count,
                    output span, output run_done, input ready);
    modport sink   (input valid, input status, input sequence_res, input good_count,
                    input span, input run_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/crc16pc_in_stage.sv */
// Input register for packet bytes.
// Depends on crc16pc_pkg and crc16pc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module crc16pc_in_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    crc16pc_in_if.sink              i_byte,
    input  wire                     i_take,
    output logic                    o_valid,
    output crc16pc_pkg::t_byte_item o_item
);

    logic                    r_valid;
    crc16pc_pkg::t_byte_item r_item;

    assign i_byte.ready = !r_valid || i_take;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_item.data_byte <= i_byte.data_byte;
            r_item.last_byte <= i_byte.last_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/crc16pc_core.sv */
// Per-byte CRC, length and sequence tracking with the result register.
// Depends on crc16pc_pkg and crc16pc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module crc16pc_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  [15:0]             i_expected,
    input  wire                     i_valid,
    input  crc16pc_pkg::t_byte_item i_item,
    output logic                    o_take,
    crc16pc_out_if.source           o_result
);

    localparam int unsigned CW = crc16pc_pkg::CNT_W;

    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_delay, n_delay;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_seq, n_seq;
    logic          r_started, n_started;
    logic [15:0]   r_origin_seq, n_origin_seq;
    logic [15:0]   r_count, n_count;
    logic          r_finished, n_finished;

    logic          r_out_valid;
    crc16pc_pkg::t_status r_status, n_status;
    logic [15:0]   r_out_seq, r_out_count, r_out_span, n_span;
    logic          r_out_done;

    logic [15:0]   eff_start;
    logic [15:0]   base_count;
    logic [17:0]   diff;
    logic          bad_len;

    assign o_take = i_valid && (!i_item.last_byte || !r_out_valid || o_result.ready);

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_status;
    assign o_result.sequence_res = r_out_seq;
    assign o_result.good_count   = r_out_count;
    assign o_result.span         = r_out_span;
    assign o_result.run_done     = r_out_done;

    always_comb begin
        n_crc = r_crc;
        if (r_cnt >= CW'(2)) begin
            n_crc = crc16pc_pkg::crc_byte(r_crc, r_delay[15:8]);
        end
        n_delay = {r_delay[7:0], i_item.data_byte};
        n_seq   = r_seq;
        if (r_cnt == CW'(1)) begin
            n_seq = {i_item.data_byte, r_seq[7:0]};
        end else if (r_cnt == CW'(2)) begin
            n_seq = {r_seq[15:8], i_item.data_byte};
        end
        n_cnt = (r_cnt != crc16pc_pkg::CNT_MAX) ? r_cnt + CW'(1) : r_cnt;

        bad_len    = (n_cnt < CW'(crc16pc_pkg::MIN_PACKET_BYTES)) ||
                     (n_cnt > CW'(crc16pc_pkg::MAX_PACKET_BYTES));
        eff_start  = r_started ? r_origin_seq : n_seq;
        base_count = r_started ? r_count : 16'd0;
        diff       = {2'b00, n_seq} - {2'b00, eff_start} + 18'd1;

        n_started    = r_started;
        n_origin_seq = r_origin_seq;
        n_count      = r_count;
        n_finished   = r_finished;
        n_span       = 16'd0;
        n_status     = crc16pc_pkg::ST_IGNORED;

        if (r_finished) begin
            n_status = crc16pc_pkg::ST_IGNORED;
        end else if (bad_len) begin
            n_status = crc16pc_pkg::ST_BAD_LEN;
        end else if (n_crc != n_delay) begin
            n_status = crc16pc_pkg::ST_CRC_ERR;
        end else begin
            n_started    = 1'b1;
            n_origin_seq = eff_start;
            if ($signed(diff) <= $signed({2'b00, i_expected})) begin
                n_status = crc16pc_pkg::ST_COUNTED;
                n_count  = (base_count != crc16pc_pkg::COUNT_MAX) ?
                           base_count + 16'd1 : base_count;
            end else begin
                n_status = crc16pc_pkg::ST_NOT_COUNTED;
                n_count  = base_count;
            end
            n_span = diff[15:0];
            if (n_span >= i_expected) begin
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= '0;
            r_delay      <= '0;
            r_cnt        <= '0;
            r_seq        <= '0;
            r_started    <= 1'b0;
            r_origin_seq <= '0;
            r_count      <= '0;
            r_finished   <= 1'b0;
        end else if (o_take) begin
            if (i_item.last_byte) begin
                r_crc        <= '0;
                r_delay      <= '0;
                r_cnt        <= '0;
                r_seq        <= '0;
                r_started    <= n_started;
                r_origin_seq <= n_origin_seq;
                r_count      <= n_count;
                r_finished   <= n_finished;
            end else begin
                r_crc   <= n_crc;
                r_delay <= n_delay;
                r_cnt   <= n_cnt;
                r_seq   <= n_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last_byte) begin
            r_status    <= n_status;
            r_out_seq   <= n_seq;
            r_out_count <= n_count;
            r_out_span  <= n_span;
            r_out_done  <= n_finished;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/crc16_packet_check_and_reception_count.sv */
// CRC-16 packet check and reception counter.
// Takes packet bytes with a last marker on i_byte and gives one result per
// packet on o_result. i_cfg_wr_en / i_cfg_wr_data write expected_packets
// (reset value 100); write it only while no packet is in progress.
// Each packet's last byte yields status, sequence number, good count, span and
// run_done. Throughput: one byte per cycle unless a last byte waits on a
// stalled result; the byte-wide CRC update and the packet checks sit
// between the input register and the result register.
// Reset (i_rst_n low, synchronous) clears packet state, counter, start
// sequence and done flag, and empties both registers.
// When the receiver stalls, the result holds; non-last bytes keep flowing,
// and the next last byte waits in the input register until the result is
// taken, with i_byte.ready low meanwhile.
// Depends on crc16pc_pkg, crc16pc_if, crc16pc_in_stage, crc16pc_core.
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_check_and_reception_count (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [15:0]  i_cfg_wr_data,
    crc16pc_in_if.sink   i_byte,
    crc16pc_out_if.source o_result
);

    logic [15:0]             r_expected;
    logic                    in_valid;
    logic                    take;
    crc16pc_pkg::t_byte_item in_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= crc16pc_pkg::EXPECTED_RESET;
        end else if (i_cfg_wr_en) begin
            r_expected <= i_cfg_wr_data;
        end
    end

    crc16pc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    crc16pc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_expected (r_expected),
        .i_valid    (in_valid),
        .i_item     (in_item),
        .o_take     (take),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/crc16pc_checker.sv */
// Port-level checks on the result channel of the CRC-16 packet check block.
// Depends on assert_macros.svh, crc16pc_pkg and crc16pc_if; bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crc16pc_checker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    crc16pc_out_if.source o_result
);

    `ASSERT_CLK_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_result.valid)

    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n,
        o_result.valid && !o_result.ready |=> o_result.valid && $stable(o_result.span))

    `ASSERT_CLK(a_reject_no_span, i_clk, i_rst_n,
        o_result.valid && (o_result.status == crc16pc_pkg::ST_CRC_ERR ||
        o_result.status == crc16pc_pkg::ST_BAD_LEN ||
        o_result.status == crc16pc_pkg::ST_IGNORED) |-> o_result.span == 16'd0)

    `ASSERT_CLK(a_ignored_done, i_clk, i_rst_n,
        o_result.valid && o_result.status == crc16pc_pkg::ST_IGNORED |-> o_result.run_done)

    `ASSERT_CLK(a_counted_nonzero, i_clk, i_rst_n,
        o_result.valid && o_result.status == crc16pc_pkg::ST_COUNTED |->
        o_result.good_count != 16'd0)

endmodule

bind crc16_packet_check_and_reception_count crc16pc_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_result (o_result)
);

`default_nettype wire
